### rtl/mpsse_jtag_command_parser_assert.svh
// ----------------------------------------------------------------------------
// MPSSE JTAG command parser assertion macros
// Concurrent checks that disappear when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MPSSE_JTAG_COMMAND_PARSER_ASSERT_SVH
`define MPSSE_JTAG_COMMAND_PARSER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MJCP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mjcp check failed");
// next-cycle implication
`define MJCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mjcp check failed");
`else
`define MJCP_ASSERT_NOW(label, clk, rst, ante, cons)
`define MJCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/mjcp_pkg.sv
// ----------------------------------------------------------------------------
// mjcp_pkg
// Parse phases, action codes, command codes, delay tables and result type
// for the MPSSE JTAG command parser.
// ----------------------------------------------------------------------------
package mjcp_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_DATA,
      PH_TMS_DATA,
      PH_PARAM0,
      PH_PARAM1
   } phase_type;

   localparam logic [2:0] ACT_BAD_CMD   = 3'd0;
   localparam logic [2:0] ACT_SET_PINS  = 3'd1;
   localparam logic [2:0] ACT_READ_PINS = 3'd2;
   localparam logic [2:0] ACT_FLUSH     = 3'd3;
   localparam logic [2:0] ACT_SHIFT_TDI = 3'd4;
   localparam logic [2:0] ACT_SHIFT_TMS = 3'd5;
   localparam logic [2:0] ACT_CLOCKS    = 3'd6;

   localparam logic [7:0] CMD_SET_LOW     = 8'h80;
   localparam logic [7:0] CMD_READ_LOW    = 8'h81;
   localparam logic [7:0] CMD_SET_HIGH    = 8'h82;
   localparam logic [7:0] CMD_READ_HIGH   = 8'h83;
   localparam logic [7:0] CMD_LOOP_ON     = 8'h84;
   localparam logic [7:0] CMD_LOOP_OFF    = 8'h85;
   localparam logic [7:0] CMD_SET_DIVISOR = 8'h86;
   localparam logic [7:0] CMD_FLUSH       = 8'h87;
   localparam logic [7:0] CMD_WAIT_H      = 8'h88;
   localparam logic [7:0] CMD_WAIT_L      = 8'h89;
   localparam logic [7:0] CMD_DIV5_OFF    = 8'h8a;
   localparam logic [7:0] CMD_DIV5_ON     = 8'h8b;
   localparam logic [7:0] CMD_CLK_WAIT_H  = 8'h8c;
   localparam logic [7:0] CMD_CLK_WAIT_L  = 8'h8d;
   localparam logic [7:0] CMD_CLK_BITS    = 8'h8e;
   localparam logic [7:0] CMD_CLK_BYTES   = 8'h8f;
   localparam logic [7:0] CMD_ADAPT_ON    = 8'h96;
   localparam logic [7:0] CMD_ADAPT_OFF   = 8'h97;

   localparam int SLOW_MAX = 5;
   localparam int FAST_MAX = 15;

   localparam logic [4:0] SLOW_DELAY [SLOW_MAX+1] = '{5'd1, 5'd5, 5'd8, 5'd12, 5'd16, 5'd20};
   localparam logic [4:0] FAST_DELAY [FAST_MAX+1] = '{
      5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd2, 5'd3, 5'd4,
      5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd8, 5'd9
   };

   typedef struct packed {
      logic [2:0]  action;
      logic        bank;
      logic [7:0]  pin_value;
      logic [7:0]  pin_direction;
      logic [7:0]  data_byte;
      logic [16:0] bit_count;
      logic [19:0] repeat_count;
      logic        lsb_first;
      logic        write_on_falling;
      logic        capture_tdo;
      logic        tdi_level;
      logic [4:0]  tck_delay;
   } result_type;

   // Shift action with the command flags filled in
   function automatic result_type shift_result(input logic [7:0]  cmd,
                                               input logic [2:0]  act,
                                               input logic [7:0]  data,
                                               input logic [16:0] bits,
                                               input logic [19:0] reps,
                                               input logic [4:0]  delay);
      result_type r;
      r                  = '0;
      r.action           = act;
      r.data_byte        = data;
      r.bit_count        = bits;
      r.repeat_count     = reps;
      r.lsb_first        = (act == ACT_SHIFT_TMS) ? 1'b1 : cmd[3];
      r.write_on_falling = cmd[0];
      r.capture_tdo      = cmd[5];
      r.tdi_level        = (act == ACT_SHIFT_TMS) ? data[7] : 1'b0;
      r.tck_delay        = delay;
      return r;
   endfunction

endpackage

### rtl/mpsse_jtag_command_parser.sv
// ----------------------------------------------------------------------------
// mpsse_jtag_command_parser
// Decodes an MPSSE command byte stream into JTAG actions for a shift engine.
// ----------------------------------------------------------------------------
// One command byte is taken per cycle while req_ready is high. Each accepted
// byte updates the parse state and, when it completes an action, loads the
// result register; the action appears on the rsp_ port in the next cycle.
// req_ready stays high while the result register is empty or is being taken
// in the same cycle, so a result that waits holds up the stream until it is
// taken. Throughput is one byte per cycle unless stalled, set by the single
// parse-state update between the request and the result register.
module mpsse_jtag_command_parser
   import mjcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_cmd_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic        rsp_bank,
   output logic [7:0]  rsp_pin_value,
   output logic [7:0]  rsp_pin_direction,
   output logic [7:0]  rsp_data_byte,
   output logic [16:0] rsp_bit_count,
   output logic [19:0] rsp_repeat_count,
   output logic        rsp_lsb_first,
   output logic        rsp_write_on_falling,
   output logic        rsp_capture_tdo,
   output logic        rsp_tdi_level,
   output logic [4:0]  rsp_tck_delay
);

`include "mpsse_jtag_command_parser_assert.svh"

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  param_ff, param_in;
   logic        div5_ff, div5_in;
   logic [4:0]  delay_ff, delay_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  out_ff, out_in;

   logic        accept;
   logic        res_valid;
   result_type  res;
   logic [7:0]  b;
   logic        bit_mode;
   logic [15:0] len_new;
   logic [15:0] divisor;
   logic [16:0] len_plus1;
   logic [16:0] param_plus1;
   logic [2:0]  slow_idx;
   logic [3:0]  fast_idx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_cmd_byte;
   assign bit_mode  = cmd_ff[1];
   assign divisor   = {b, param_ff};
   assign slow_idx  = (divisor > 16'(SLOW_MAX)) ? 3'(SLOW_MAX) : divisor[2:0];
   assign fast_idx  = (divisor > 16'(FAST_MAX)) ? 4'(FAST_MAX) : divisor[3:0];

   // Length as it stands after this byte (only meaningful in the length phases)
   always_comb begin
      len_new = len_ff;
      if (phase_ff == PH_LEN_LO) begin
         len_new = {8'h00, b};
      end else if (phase_ff == PH_LEN_HI) begin
         len_new = {b, len_ff[7:0]};
      end
   end

   assign len_plus1   = {1'b0, len_new} + 17'd1;
   assign param_plus1 = {1'b0, divisor} + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      param_in  = param_ff;
      div5_in   = div5_ff;
      delay_in  = delay_ff;
      res_valid = 1'b0;
      res       = '0;
      res.tck_delay = delay_ff;

      unique case (phase_ff)
         PH_LEN_LO, PH_LEN_HI: begin
            len_in = len_new;
            if (phase_ff == PH_LEN_LO && !bit_mode) begin
               phase_in = PH_LEN_HI;
            end else if (cmd_ff[6]) begin
               phase_in = PH_TMS_DATA;
            end else if (cmd_ff[4]) begin
               phase_in = PH_DATA;
            end else begin
               // read-only shift: one action covers the whole run
               phase_in  = PH_IDLE;
               res_valid = 1'b1;
               if (bit_mode) begin
                  res = shift_result(cmd_ff, ACT_SHIFT_TDI, 8'hff, len_plus1, 20'd1, delay_ff);
               end else begin
                  res = shift_result(cmd_ff, ACT_SHIFT_TDI, 8'hff, 17'd8,
                                     {3'b000, len_plus1}, delay_ff);
               end
            end
         end
         PH_DATA: begin
            res_valid = 1'b1;
            if (bit_mode) begin
               res      = shift_result(cmd_ff, ACT_SHIFT_TDI, b, len_plus1, 20'd1, delay_ff);
               phase_in = PH_IDLE;
            end else begin
               res = shift_result(cmd_ff, ACT_SHIFT_TDI, b, 17'd8, 20'd1, delay_ff);
               if (len_ff == 16'd0) begin
                  phase_in = PH_IDLE;
               end else begin
                  len_in = len_ff - 16'd1;
               end
            end
         end
         PH_TMS_DATA: begin
            res_valid = 1'b1;
            res       = shift_result(cmd_ff, ACT_SHIFT_TMS, b, len_plus1, 20'd1, delay_ff);
            phase_in  = PH_IDLE;
         end
         PH_PARAM0: begin
            param_in = b;
            if (cmd_ff == CMD_CLK_BITS) begin
               phase_in         = PH_IDLE;
               res_valid        = 1'b1;
               res.action       = ACT_CLOCKS;
               res.repeat_count = 20'(b) + 20'd1;
            end else begin
               phase_in = PH_PARAM1;
            end
         end
         PH_PARAM1: begin
            phase_in = PH_IDLE;
            if (cmd_ff == CMD_SET_DIVISOR) begin
               // mode is sampled now; a later mode change leaves the delay alone
               delay_in = div5_ff ? SLOW_DELAY[slow_idx] : FAST_DELAY[fast_idx];
            end else if (cmd_ff == CMD_CLK_BYTES) begin
               res_valid        = 1'b1;
               res.action       = ACT_CLOCKS;
               res.repeat_count = {param_plus1, 3'b000};
            end else begin
               res_valid         = 1'b1;
               res.action        = ACT_SET_PINS;
               res.bank          = cmd_ff[1];
               res.pin_value     = param_ff;
               res.pin_direction = b;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cmd_in   = b;
            if (b[7]) begin
               unique case (b)
                  CMD_SET_LOW, CMD_SET_HIGH, CMD_SET_DIVISOR, CMD_CLK_BITS,
                  CMD_CLK_BYTES: begin
                     phase_in = PH_PARAM0;
                  end
                  CMD_READ_LOW, CMD_READ_HIGH: begin
                     res_valid  = 1'b1;
                     res.action = ACT_READ_PINS;
                     res.bank   = b[1];
                  end
                  CMD_FLUSH: begin
                     res_valid  = 1'b1;
                     res.action = ACT_FLUSH;
                  end
                  CMD_DIV5_OFF: div5_in = 1'b0;
                  CMD_DIV5_ON:  div5_in = 1'b1;
                  CMD_LOOP_ON, CMD_LOOP_OFF, CMD_WAIT_H, CMD_WAIT_L,
                  CMD_CLK_WAIT_H, CMD_CLK_WAIT_L, CMD_ADAPT_ON, CMD_ADAPT_OFF: begin
                     // drop silently
                  end
                  default: begin
                     res_valid     = 1'b1;
                     res.action    = ACT_BAD_CMD;
                     res.data_byte = b;
                  end
               endcase
            end else if (!(b[6] && !b[3])) begin
               phase_in = PH_LEN_LO;
            end else begin
               // TMS shift must be LSB first
               res_valid     = 1'b1;
               res.action    = ACT_BAD_CMD;
               res.data_byte = b;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cmd_ff       <= 8'h00;
         len_ff       <= 16'h0000;
         param_ff     <= 8'h00;
         div5_ff      <= 1'b1;
         delay_ff     <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            len_ff   <= len_in;
            param_ff <= param_in;
            div5_ff  <= div5_in;
            delay_ff <= delay_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = out_ff.action;
   assign rsp_bank             = out_ff.bank;
   assign rsp_pin_value        = out_ff.pin_value;
   assign rsp_pin_direction    = out_ff.pin_direction;
   assign rsp_data_byte        = out_ff.data_byte;
   assign rsp_bit_count        = out_ff.bit_count;
   assign rsp_repeat_count     = out_ff.repeat_count;
   assign rsp_lsb_first        = out_ff.lsb_first;
   assign rsp_write_on_falling = out_ff.write_on_falling;
   assign rsp_capture_tdo      = out_ff.capture_tdo;
   assign rsp_tdi_level        = out_ff.tdi_level;
   assign rsp_tck_delay        = out_ff.tck_delay;

   `MJCP_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready)
   `MJCP_ASSERT_NEXT(a_flush_result, clock, reset,
      accept && phase_ff == PH_IDLE && b == CMD_FLUSH,
      rsp_valid_ff && out_ff.action == ACT_FLUSH)
   `MJCP_ASSERT_NEXT(a_divisor_silent, clock, reset,
      accept && phase_ff == PH_PARAM1 && cmd_ff == CMD_SET_DIVISOR, !rsp_valid_ff)
   `MJCP_ASSERT_NOW(a_delay_range, clock, reset, 1'b1, delay_ff != 5'd0 && delay_ff <= 5'd20)

endmodule
